// File: design/cft_pkg.sv
// cft_pkg: shared types and constants of the csv field tokenizer
// character class codes, event codes and the queue entry type
// no dependencies
package cft_pkg;

	localparam int CHAR_W = 16;
	localparam int KIND_W = 3;
	localparam int CLS_W  = 3;
	localparam int ROW_W  = 16;
	localparam int COLN_W = 8;

	localparam logic [CHAR_W-1:0] CH_QUOTE = 16'h0022;
	localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
	localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
	localparam logic [CHAR_W-1:0] CH_NUL   = 16'h0000;
	localparam logic [CHAR_W-1:0] SEP_RESET = 16'd44;

	localparam logic [ROW_W-1:0] ROW_MAX = 16'hFFFF;

	// character classes, decided in the front end
	localparam logic [CLS_W-1:0] CLS_CHAR  = 3'd0;
	localparam logic [CLS_W-1:0] CLS_END   = 3'd1;
	localparam logic [CLS_W-1:0] CLS_QUOTE = 3'd2;
	localparam logic [CLS_W-1:0] CLS_CR    = 3'd3;
	localparam logic [CLS_W-1:0] CLS_SEP   = 3'd4;
	localparam logic [CLS_W-1:0] CLS_LF    = 3'd5;

	// result event codes
	localparam logic [KIND_W-1:0] EV_FIELD_CHAR = 3'd0;
	localparam logic [KIND_W-1:0] EV_FIELD_END  = 3'd1;
	localparam logic [KIND_W-1:0] EV_FINISHED   = 3'd2;
	localparam logic [KIND_W-1:0] EV_COL_BEYOND = 3'd3;
	localparam logic [KIND_W-1:0] EV_HDR_WIDE   = 3'd4;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [CLS_W-1:0]  cls;
		logic [CHAR_W-1:0] ch;
		logic              sof;
	} cft_item_t;

endpackage

// File: design/cft_if.sv
// cft_if: valid/ready channel interfaces of the csv field tokenizer
// cft_in_if carries text characters, cft_out_if carries tokenizer events
// depends on cft_pkg for field widths
interface cft_in_if;
	import cft_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              end_of_text;
	logic              start_of_file;

	modport source (output valid, output char_code, output end_of_text,
		output start_of_file, input ready);
	modport sink (input valid, input char_code, input end_of_text,
		input start_of_file, output ready);
endinterface

interface cft_out_if;
	import cft_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] event_kind;
	logic [CHAR_W-1:0] text_char;
	logic [COLN_W-1:0] column_number;
	logic [ROW_W-1:0]  row_number;
	logic              record_end;
	logic              text_end;

	modport source (output valid, output event_kind, output text_char,
		output column_number, output row_number, output record_end,
		output text_end, input ready);
	modport sink (input valid, input event_kind, input text_char,
		input column_number, input row_number, input record_end,
		input text_end, output ready);
endinterface

// File: design/cft_front.sv
// cft_front: accepts characters, holds the separator register and classifies each item
// pushes classified items into the queue; depends on cft_pkg and cft_if
module cft_front (
	input  logic              clk,
	input  logic              arst_n,
	cft_in_if.sink            items,
	input  logic              separator_wr_en,
	input  logic [15:0]       separator_wr_data,
	output logic              push,
	output cft_pkg::cft_item_t push_item,
	input  logic              push_ready
);
	import cft_pkg::*;

	logic [CHAR_W-1:0] sep_q;
	logic [CLS_W-1:0]  cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= SEP_RESET;
		end else if (separator_wr_en) begin
			sep_q <= separator_wr_data;
		end
	end

	// terminator and nul win over everything, a separator loses to quote and cr
	always_comb begin
		if (items.end_of_text || items.char_code == CH_NUL) begin
			cls = CLS_END;
		end else if (items.char_code == CH_QUOTE) begin
			cls = CLS_QUOTE;
		end else if (items.char_code == CH_CR) begin
			cls = CLS_CR;
		end else if (items.char_code == sep_q) begin
			cls = CLS_SEP;
		end else if (items.char_code == CH_LF) begin
			cls = CLS_LF;
		end else begin
			cls = CLS_CHAR;
		end
	end

	assign items.ready   = push_ready;
	assign push          = items.valid && push_ready;
	assign push_item.cls = cls;
	assign push_item.ch  = items.char_code;
	assign push_item.sof = items.start_of_file;

endmodule

// File: design/cft_queue.sv
// cft_queue: short register queue between the classifier and the parser
// depends on cft_pkg for the entry type and depth
module cft_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cft_pkg::cft_item_t push_item,
	output logic               push_ready,
	input  logic               pop,
	output logic               head_valid,
	output cft_pkg::cft_item_t head_item
);
	import cft_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cft_item_t        entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/cft_back.sv
// cft_back: parse state machine of the tokenizer and the result register
// takes classified items from the queue; depends on cft_pkg and cft_if
module cft_back #(
	parameter int MAX_COLUMNS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  cft_pkg::cft_item_t head_item,
	output logic               pop,
	cft_out_if.source          results
);
	import cft_pkg::*;

	localparam int COL_W = $clog2(MAX_COLUMNS + 1);
	localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_COLUMNS);

	logic             in_quotes_q, pending_q, has_chars_q, stopped_q;
	logic [COL_W-1:0] col_q, hdr_cols_q;
	logic [ROW_W-1:0] row_q;

	// state after an optional start-of-file clear
	logic             iq_b, pend_b, fhc_b, stop_b;
	logic [COL_W-1:0] col_b, hc_b;
	logic [ROW_W-1:0] row_b;

	logic             iq_n, pend_n, fhc_n, stop_n;
	logic [COL_W-1:0] col_n, hc_n;
	logic [ROW_W-1:0] row_n;

	logic              res_v;
	logic [KIND_W-1:0] res_kind;
	logic [CHAR_W-1:0] res_char;
	logic              res_rec, res_te;

	logic              iq_eff, hdr_row, ef_ok;
	logic [KIND_W-1:0] ef_kind;
	logic [31:0]       col_ext;

	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [CHAR_W-1:0] char_q;
	logic [COLN_W-1:0] coln_q;
	logic [ROW_W-1:0]  rown_q;
	logic              rec_q, te_q;

	assign pop = head_valid && (!out_valid_q || results.ready);

	always_comb begin
		if (head_item.sof) begin
			iq_b = 1'b0; pend_b = 1'b0; fhc_b = 1'b0; stop_b = 1'b0;
			col_b = '0; hc_b = '0; row_b = '0;
		end else begin
			iq_b = in_quotes_q; pend_b = pending_q; fhc_b = has_chars_q;
			stop_b = stopped_q; col_b = col_q; hc_b = hdr_cols_q; row_b = row_q;
		end

		// field end check, shared by separator, newline and flush
		hdr_row = row_b == '0;
		ef_ok   = hdr_row ? (hc_b != COL_MAX) : (col_b < hc_b);
		if (ef_ok) begin
			ef_kind = EV_FIELD_END;
		end else if (hdr_row) begin
			ef_kind = EV_HDR_WIDE;
		end else begin
			ef_kind = EV_COL_BEYOND;
		end

		iq_n = iq_b; pend_n = pend_b; fhc_n = fhc_b; stop_n = stop_b;
		col_n = col_b; hc_n = hc_b; row_n = row_b;
		res_v = 1'b0; res_kind = EV_FIELD_CHAR; res_char = '0;
		res_rec = 1'b0; res_te = 1'b0;
		iq_eff = pend_b ? !iq_b : iq_b;

		if (!stop_b) begin
			if (pend_b && head_item.cls == CLS_QUOTE) begin
				// doubled quote gives one literal quote
				pend_n = 1'b0;
				fhc_n = 1'b1;
				res_v = 1'b1; res_char = CH_QUOTE;
			end else begin
				pend_n = 1'b0;
				iq_n = iq_eff;
				case (head_item.cls)
					CLS_END: begin
						stop_n = 1'b1;
						res_v = 1'b1;
						if (!fhc_b) begin
							res_kind = EV_FINISHED;
						end else begin
							res_kind = ef_kind;
							if (ef_ok) begin
								res_rec = 1'b1; res_te = 1'b1; fhc_n = 1'b0;
								if (hdr_row) hc_n = hc_b + 1'b1;
							end
						end
					end
					CLS_QUOTE: begin
						pend_n = 1'b1;
					end
					default: begin
						if (iq_eff) begin
							fhc_n = 1'b1;
							res_v = 1'b1; res_char = head_item.ch;
						end else if (head_item.cls == CLS_SEP) begin
							res_v = 1'b1; res_kind = ef_kind;
							if (ef_ok) begin
								fhc_n = 1'b0;
								if (hdr_row) hc_n = hc_b + 1'b1;
								if (col_b < COL_MAX) col_n = col_b + 1'b1;
							end else begin
								stop_n = 1'b1;
							end
						end else if (head_item.cls == CLS_LF) begin
							res_v = 1'b1;
							if (!fhc_b && col_b == '0) begin
								// blank line ends the parse
								stop_n = 1'b1; res_kind = EV_FINISHED;
							end else begin
								res_kind = ef_kind;
								if (ef_ok) begin
									res_rec = 1'b1; fhc_n = 1'b0; col_n = '0;
									if (hdr_row) hc_n = hc_b + 1'b1;
									if (row_b != ROW_MAX) row_n = row_b + 1'b1;
								end else begin
									stop_n = 1'b1;
								end
							end
						end else if (head_item.cls == CLS_CHAR) begin
							fhc_n = 1'b1;
							res_v = 1'b1; res_char = head_item.ch;
						end
						// a carriage return outside quotes is dropped
					end
				endcase
			end
		end
		col_ext = 32'(col_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quotes_q <= 1'b0;
			pending_q   <= 1'b0;
			has_chars_q <= 1'b0;
			stopped_q   <= 1'b0;
			col_q       <= '0;
			hdr_cols_q  <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				in_quotes_q <= iq_n;
				pending_q   <= pend_n;
				has_chars_q <= fhc_n;
				stopped_q   <= stop_n;
				col_q       <= col_n;
				hdr_cols_q  <= hc_n;
				row_q       <= row_n;
			end
			if (pop && res_v) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_v) begin
			kind_q <= res_kind;
			char_q <= res_char;
			coln_q <= col_ext[COLN_W-1:0];
			rown_q <= row_b;
			rec_q  <= res_rec;
			te_q   <= res_te;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.event_kind    = kind_q;
	assign results.text_char     = char_q;
	assign results.column_number = coln_q;
	assign results.row_number    = rown_q;
	assign results.record_end    = rec_q;
	assign results.text_end      = te_q;

endmodule

// File: design/csv_field_tokenizer.sv
// csv_field_tokenizer: top level of the streaming csv tokenizer
// joins the classifier front end, the item queue and the parser back end
// depends on cft_pkg, cft_if, cft_front, cft_queue and cft_back

// One UTF-16 character is taken per cycle and at most one event comes out per
// character, at a sustained rate of one item per cycle when the result side keeps
// taking. A character is classified as it is accepted and held in a four-entry
// queue; the parser takes the queue head, updates its parse state and places any
// event in the output register, so each event passes through the queue entry and
// the output register before it is presented on the result side. When the queue
// is full the input is held off, and it frees again in the cycle after the parser
// takes an entry. The separator register may only be written while no items are
// in flight. Column counts saturate at MAX_COLUMNS and the row number saturates
// at 65535.
module csv_field_tokenizer #(
	parameter int MAX_COLUMNS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	cft_in_if.sink      items,
	cft_out_if.source   results,
	input  logic        separator_wr_en,
	input  logic [15:0] separator_wr_data
);
	import cft_pkg::*;

	logic      push, push_ready, pop, head_valid;
	cft_item_t push_item, head_item;

	cft_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.items             (items),
		.separator_wr_en   (separator_wr_en),
		.separator_wr_data (separator_wr_data),
		.push              (push),
		.push_item         (push_item),
		.push_ready        (push_ready)
	);

	cft_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	cft_back #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.results    (results)
	);

endmodule
